// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define CHK_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CHK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CHK_RST(label, clk, rst, prop, msg)
`define CHK_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ===== hw/rtl/wphs_pkg.sv =====
`default_nettype none

package wphs_pkg;

  typedef enum logic [1:0] {
    CMD_POSE  = 2'd0,
    CMD_PUSH  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_SPIN  = 2'd3
  } cmd_t;

  localparam logic [1:0] SPIN_NONE = 2'd0;
  localparam logic [1:0] SPIN_CW   = 2'd1;
  localparam logic [1:0] SPIN_CCW  = 2'd2;

  localparam logic [1:0] REG_POS_TOL   = 2'd0;
  localparam logic [1:0] REG_DEADBAND  = 2'd1;
  localparam logic [1:0] REG_FWD_SPEED = 2'd2;

  localparam logic [15:0] POS_TOL_RESET   = 16'd38;
  localparam logic [13:0] DEADBAND_RESET  = 14'd521;
  localparam logic [9:0]  FWD_SPEED_RESET = 10'd160;

  // rad/s * 4096
  localparam logic signed [15:0] RATE_FULL    = 16'sd25736;
  localparam logic signed [15:0] RATE_HALF    = 16'sd12868;
  localparam logic signed [15:0] RATE_QUARTER = 16'sd3217;
  localparam logic signed [15:0] RATE_EIGHTH  = 16'sd1608;

  // error band edges, binary angle units
  localparam logic [16:0] HALF_TURN    = 17'd32768;
  localparam logic [16:0] FULL_TURN    = 17'd65536;
  localparam logic [16:0] BAND_HALF    = 17'd16384;
  localparam logic [16:0] BAND_QUARTER = 17'd4096;

  typedef struct packed {
    cmd_t               command;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0]        heading;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic [1:0]         spin_select;
  } cmd_beat_t;

  typedef struct packed {
    logic [9:0]         linear_speed;
    logic signed [15:0] angular_rate;
    logic [4:0]         queue_count;
    logic               push_dropped;
  } rsp_beat_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
  } waypoint_t;

  // atan(2^-i) in 1/16 binary angle units
  function automatic logic [17:0] atan_step(input logic [3:0] i);
    logic [17:0] v;
    case (i)
      4'd0:    v = 18'd131072;
      4'd1:    v = 18'd77376;
      4'd2:    v = 18'd40884;
      4'd3:    v = 18'd20753;
      4'd4:    v = 18'd10417;
      4'd5:    v = 18'd5213;
      4'd6:    v = 18'd2607;
      4'd7:    v = 18'd1304;
      4'd8:    v = 18'd652;
      4'd9:    v = 18'd326;
      4'd10:   v = 18'd163;
      4'd11:   v = 18'd81;
      4'd12:   v = 18'd41;
      4'd13:   v = 18'd20;
      4'd14:   v = 18'd10;
      4'd15:   v = 18'd5;
      default: v = 18'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/waypoint_heading_steering_top.sv =====
// Channel  Beat type               Handshake
// cmd      wphs_pkg::cmd_beat_t    cmd_valid / cmd_stall
// rsp      wphs_pkg::rsp_beat_t    rsp_valid / rsp_stall
// cfg      16-bit data, 2-bit idx  cfg_we, no handshake back
//
// Push, clear, set-spin, and a pose beat with spin or an empty queue go straight to ST_EMIT.
// A pose beat pops reached waypoints in ST_LOOK, reading each new front from RAM; if the
// queue empties it goes to ST_EMIT, else it runs 16 CORDIC iterations in ST_AIM, then ST_STEER.
// One command beat in flight; cmd_stall is high until its result is loaded into rsp.
// Reset: queue empty, spin off, held speed and rate zero, registers at defaults;
// waypoint RAM is not cleared. A result held by rsp_stall blocks only the next load.
`default_nettype none
`include "assert_macros.svh"

module waypoint_heading_steering_top #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cmd_valid,
  output logic                      cmd_stall,
  input  wire wphs_pkg::cmd_beat_t  cmd,
  output logic                      rsp_valid,
  input  wire logic                 rsp_stall,
  output wphs_pkg::rsp_beat_t       rsp,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [15:0]          cfg_data
);

  localparam int HW = $clog2(QUEUE_DEPTH);
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int CW = FW + 5;
  localparam logic [FW-1:0] FILL_MAX = FW'(QUEUE_DEPTH);
  localparam logic [HW:0]   SLOT_WRAP = (HW+1)'(QUEUE_DEPTH);
  localparam logic [HW-1:0] HEAD_LAST = HW'(QUEUE_DEPTH - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_AIM,
    ST_STEER,
    ST_EMIT
  } state_t;

  state_t             state;
  logic [15:0]        pos_tol;
  logic [13:0]        deadband;
  logic [9:0]         fwd_speed;
  logic [HW-1:0]      q_head;
  logic [FW-1:0]      q_fill;
  logic [1:0]         spin_state;
  logic [9:0]         held_linear;
  logic signed [15:0] held_angular;
  logic               dropped;
  logic signed [15:0] px;
  logic signed [15:0] py;
  logic [15:0]        yaw;
  logic [15:0]        brg;

  // queue addressing
  logic [HW-1:0]      head_inc;
  logic [HW:0]        slot_sum;
  logic [HW-1:0]      push_slot;
  logic [CW-1:0]      fill_wide;

  // RAM ports
  logic               ram_we;
  logic               ram_re;
  logic [HW-1:0]      ram_raddr;
  logic [31:0]        ram_rdata;
  wphs_pkg::waypoint_t front;
  wphs_pkg::waypoint_t new_point;

  // reach test / CORDIC
  logic signed [16:0] ex;
  logic signed [16:0] ey;
  logic [16:0]        ex_abs;
  logic [16:0]        ey_abs;
  logic               reached;
  logic               pop;
  logic               cord_start;
  logic               cord_done;
  logic [15:0]        cord_bearing;

  // steering decision
  logic [15:0]        diff;
  logic [16:0]        err;
  logic signed [15:0] band_rate;
  logic [9:0]         steer_linear;
  logic signed [15:0] steer_angular;

  logic               accept;
  logic               pose_look;
  logic               emit_go;

  assign accept    = cmd_valid && !cmd_stall;
  assign cmd_stall = (state != ST_IDLE);
  assign emit_go   = (state == ST_EMIT) && (!rsp_valid || !rsp_stall);

  always_comb begin
    head_inc  = (q_head == HEAD_LAST) ? '0 : q_head + HW'(1);
    slot_sum  = (HW+1)'(q_head) + (HW+1)'(q_fill);
    push_slot = (slot_sum >= SLOT_WRAP) ? HW'(slot_sum - SLOT_WRAP) : slot_sum[HW-1:0];
    fill_wide = CW'(q_fill);

    front     = wphs_pkg::waypoint_t'(ram_rdata);
    new_point = '{x: cmd.point_x, y: cmd.point_y};

    ex      = {front.x[15], front.x} - {px[15], px};
    ey      = {front.y[15], front.y} - {py[15], py};
    ex_abs  = ex[16] ? 17'(-ex) : 17'(ex);
    ey_abs  = ey[16] ? 17'(-ey) : 17'(ey);
    reached = (ex_abs < {1'b0, pos_tol}) && (ey_abs < {1'b0, pos_tol});
    pop        = (state == ST_LOOK) && reached;
    cord_start = (state == ST_LOOK) && !reached;

    pose_look = accept && (cmd.command == wphs_pkg::CMD_POSE) &&
                (spin_state != wphs_pkg::SPIN_CW) && (spin_state != wphs_pkg::SPIN_CCW) &&
                (q_fill != '0);
    ram_we    = accept && (cmd.command == wphs_pkg::CMD_PUSH) && (q_fill < FILL_MAX);
    // keep reading the new front while popping
    ram_re    = pose_look || (pop && (q_fill != FW'(1)));
    ram_raddr = (state == ST_LOOK) ? head_inc : q_head;

    diff = brg - yaw;
    err  = ({1'b0, diff} <= wphs_pkg::HALF_TURN) ? {1'b0, diff}
                                                 : wphs_pkg::FULL_TURN - {1'b0, diff};
    if (err > wphs_pkg::BAND_HALF) begin
      band_rate = wphs_pkg::RATE_HALF;
    end else if (err > wphs_pkg::BAND_QUARTER) begin
      band_rate = wphs_pkg::RATE_QUARTER;
    end else begin
      band_rate = wphs_pkg::RATE_EIGHTH;
    end
    if (err <= {3'b0, deadband}) begin
      steer_linear  = fwd_speed;
      steer_angular = '0;
    end else begin
      steer_linear  = '0;
      // exact half turn turns negative
      steer_angular = diff[15] ? -band_rate : band_rate;
    end
  end

  wphs_ram #(
    .WIDTH (32),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (push_slot),
    .wdata (new_point),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  wphs_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cord_start),
    .dx      (ex),
    .dy      (ey),
    .done    (cord_done),
    .bearing (cord_bearing)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      rsp_valid    <= 1'b0;
      pos_tol      <= wphs_pkg::POS_TOL_RESET;
      deadband     <= wphs_pkg::DEADBAND_RESET;
      fwd_speed    <= wphs_pkg::FWD_SPEED_RESET;
      q_head       <= '0;
      q_fill       <= '0;
      spin_state   <= wphs_pkg::SPIN_NONE;
      held_linear  <= '0;
      held_angular <= '0;
      dropped      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          wphs_pkg::REG_POS_TOL:   pos_tol   <= cfg_data;
          wphs_pkg::REG_DEADBAND:  deadband  <= cfg_data[13:0];
          wphs_pkg::REG_FWD_SPEED: fwd_speed <= cfg_data[9:0];
          default: ;
        endcase
      end

      if (emit_go) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            px      <= cmd.pos_x;
            py      <= cmd.pos_y;
            yaw     <= cmd.heading;
            dropped <= 1'b0;
            state   <= ST_EMIT;
            case (cmd.command)
              wphs_pkg::CMD_POSE: begin
                if (spin_state == wphs_pkg::SPIN_CW) begin
                  held_linear  <= '0;
                  held_angular <= wphs_pkg::RATE_FULL;
                end else if (spin_state == wphs_pkg::SPIN_CCW) begin
                  held_linear  <= '0;
                  held_angular <= -wphs_pkg::RATE_FULL;
                end else if (q_fill == '0) begin
                  held_linear  <= '0;
                  held_angular <= '0;
                end else begin
                  state <= ST_LOOK;
                end
              end
              wphs_pkg::CMD_PUSH: begin
                if (q_fill < FILL_MAX) begin
                  q_fill <= q_fill + FW'(1);
                end else begin
                  dropped <= 1'b1;
                end
              end
              wphs_pkg::CMD_CLEAR: begin
                q_head <= '0;
                q_fill <= '0;
              end
              wphs_pkg::CMD_SPIN: begin
                spin_state <= cmd.spin_select;
              end
              default: ;
            endcase
          end
        end
        ST_LOOK: begin
          if (reached) begin
            q_head <= head_inc;
            q_fill <= q_fill - FW'(1);
            if (q_fill == FW'(1)) begin
              held_linear  <= '0;
              held_angular <= '0;
              state        <= ST_EMIT;
            end
          end else begin
            state <= ST_AIM;
          end
        end
        ST_AIM: begin
          if (cord_done) begin
            brg   <= cord_bearing;
            state <= ST_STEER;
          end
        end
        ST_STEER: begin
          held_linear  <= steer_linear;
          held_angular <= steer_angular;
          state        <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_go) begin
            rsp.linear_speed <= held_linear;
            rsp.angular_rate <= held_angular;
            rsp.queue_count  <= fill_wide[4:0];
            rsp.push_dropped <= dropped;
            state            <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `CHK_RST(a_fill_bound, clk, rst, q_fill <= FILL_MAX, "queue fill above depth")
  `CHK_RST(a_look_nonempty, clk, rst, (state == ST_LOOK) |-> (q_fill != '0), "front read on empty queue")
  `CHK_RST(a_pop_count, clk, rst, pop |=> (q_fill == $past(q_fill) - FW'(1)), "pop did not drop fill")
  `CHK_RST(a_drop_full, clk, rst, (emit_go && dropped) |-> (q_fill == FILL_MAX), "drop with room left")
  `CHK_RST(a_drive_or_turn, clk, rst, (held_linear != '0) |-> (held_angular == '0), "speed and rate both set")

endmodule

`default_nettype wire

// ===== hw/rtl/wphs_ram.sv =====
`default_nettype none

module wphs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/wphs_cordic.sv =====
`default_nettype none

// Iterative vectoring CORDIC: bearing of (dx, dy) as a 16-bit binary angle.
// 16 micro-rotations, one per cycle; done pulses the cycle after the last.
module wphs_cordic (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [16:0] dx,
  input  wire logic signed [16:0] dy,
  output logic                    done,
  output logic [15:0]             bearing
);

  localparam int XW = 28;   // |x|,|y| stay below 2^26 after gain
  localparam int ZW = 21;
  localparam int TW = 23;
  localparam logic signed [TW-1:0] BASE_HALF = TW'(524288);  // half turn * 16
  localparam logic signed [TW-1:0] ROUND     = TW'(8);

  logic                  busy;
  logic [3:0]            step;
  logic signed [XW-1:0]  x;
  logic signed [XW-1:0]  y;
  logic signed [ZW-1:0]  z;
  logic                  half;
  logic                  zero_vec;

  logic signed [XW-1:0]  x_init;
  logic signed [XW-1:0]  y_init;
  logic signed [XW-1:0]  x_sh;
  logic signed [XW-1:0]  y_sh;
  logic signed [ZW-1:0]  angle;
  logic signed [TW-1:0]  total;

  always_comb begin
    x_init = signed'({{(XW-25){dx[16]}}, dx, 8'b0});
    y_init = signed'({{(XW-25){dy[16]}}, dy, 8'b0});
    x_sh   = x >>> step;
    y_sh   = y >>> step;
    angle  = signed'({{(ZW-18){1'b0}}, wphs_pkg::atan_step(step)});
    total  = signed'({{(TW-ZW){z[ZW-1]}}, z}) + (half ? BASE_HALF : '0) + ROUND;
    bearing = zero_vec ? 16'd0 : total[19:4];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        step     <= 4'd0;
        z        <= '0;
        half     <= dx[16];
        zero_vec <= (dx == 17'sd0) && (dy == 17'sd0);
        x        <= dx[16] ? -x_init : x_init;
        y        <= dx[16] ? -y_init : y_init;
      end else if (busy) begin
        if (!y[XW-1]) begin
          x <= x + y_sh;
          y <= y - x_sh;
          z <= z + angle;
        end else begin
          x <= x - y_sh;
          y <= y + x_sh;
          z <= z - angle;
        end
        step <= step + 4'd1;
        if (step == 4'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire
